// ===== rtl/tuf_pkg.sv =====
// Shared types and constants for the timestamped union-find block.
package tuf_pkg;
  localparam int NODES = 1024;
  localparam int NODE_W = 10;
  localparam int STAMP_W = 60;
  localparam int CNT_W = 11;
  localparam logic [STAMP_W-1:0] NEVER = 60'd1000000000000000000;
  // union by size keeps tree depth at most log2(NODES): a root path has at most NODE_W+1 nodes
  localparam int PATH_D = 16;
  localparam int PATH_W = 4;

  typedef enum logic [1:0] {
    OP_UNITE = 2'd0,
    OP_SAME  = 2'd1,
    OP_EARLY = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef struct packed {
    logic [NODE_W-1:0]  parent;
    logic [STAMP_W-1:0] stamp;
    logic [CNT_W-1:0]   count;
  } entry_t;
endpackage

// ===== rtl/tuf_ram.sv =====
// Node table memory: one write port, one registered read port.
module tuf_ram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [tuf_pkg::NODE_W-1:0] waddr,
  input  tuf_pkg::entry_t            wdata,
  input  logic [tuf_pkg::NODE_W-1:0] raddr,
  output tuf_pkg::entry_t            rdata
);
  import tuf_pkg::*;
  entry_t mem [NODES];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/timestamped_union_find.sv =====
// Timestamped union-find: forest of NODES nodes held in one node table memory.
// Input channel in_*: opcode, node_a, node_b, stamp; one result per transfer on out_*.
// Unite walks both nodes to their true roots and links the smaller set under the
// larger (ties: first under second), recording the stamp. Same walks both nodes
// following only links with join stamp <= query stamp and compares the roots.
// Earliest: the answer is the max join stamp on both paths below the node where
// they meet, capped at 10^18; node_a's path is stored, then node_b's walk scans it.
// Each node visited is one table read in states S_RD, S_WAIT and S_STEP (address, data, step).
// A walk visits at most NODE_W+1 nodes. Earliest scans the stored path one entry per
// cycle for each node_b node. Same node or opcode 3 answers in the cycle after the
// transfer. The next input is taken at the earliest in the cycle after the result transfer.
// After reset a clearing pass writes every table entry, one per cycle; in_tready
// stays low during it. One item is in work at a time; when the receiver stalls the
// result holds in the output register and in_tready is low.
module timestamped_union_find (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [87:0] in_tdata,   // opcode[1:0], node_a[11:2], node_b[21:12], stamp[81:22]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // connected[0], earliest_stamp[60:1], merged[61]
);
  import tuf_pkg::*;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_RD, S_WAIT, S_STEP, S_PB, S_PW, S_PS, S_LINK, S_OUT
  } state_t;

  state_t state_r;
  logic [NODE_W:0] clr_r;
  logic [1:0] op_r;
  logic [NODE_W-1:0] xb_r, cur_r;
  logic [STAMP_W-1:0] t_r, ma_r, mb_r;
  logic sel_r;          // which side is walking: 0 = a, 1 = b
  logic [NODE_W-1:0] ra_r, rb_r;
  entry_t ea_r, eb_r;   // root entries (unite)
  logic ph_r;           // earliest: 0 gather path a, 1 walk b
  logic [NODE_W-1:0] path_n [PATH_D];
  logic [STAMP_W-1:0] path_m [PATH_D];
  logic [PATH_W-1:0] plen_r, pidx_r;
  logic [STAMP_W-1:0] best_r;
  logic found_r;
  logic [63:0] out_r;
  logic out_v_r;

  logic we;
  logic [NODE_W-1:0] waddr, raddr;
  entry_t wdata, rdata;

  tuf_ram u_ram (.clk, .we, .waddr, .wdata, .raddr, .rdata);

  wire [1:0] in_op = in_tdata[1:0];
  wire [NODE_W-1:0] in_a = in_tdata[11:2];
  wire [NODE_W-1:0] in_b = in_tdata[21:12];
  wire [STAMP_W-1:0] in_t = in_tdata[81:22];

  assign in_tready = (state_r == S_IDLE) && !out_v_r;
  assign out_tvalid = out_v_r;
  assign out_tdata = out_r;

  // stop test for the node just read
  logic is_root, stop_here;
  always_comb begin
    is_root = (rdata.parent == cur_r);
    stop_here = is_root || ((op_r == OP_SAME) && (rdata.stamp > t_r));
  end

  always_comb begin
    we = 1'b0;
    waddr = clr_r[NODE_W-1:0];
    wdata = '{parent: clr_r[NODE_W-1:0], stamp: NEVER, count: CNT_W'(1)};
    raddr = cur_r;
    if (state_r == S_CLR) we = 1'b1;
    else if (state_r == S_LINK) begin
      we = 1'b1;
      if (ea_r.count > eb_r.count) begin
        waddr = rb_r;
        wdata = '{parent: ra_r, stamp: t_r, count: eb_r.count};
      end else begin
        waddr = ra_r;
        wdata = '{parent: rb_r, stamp: t_r, count: ea_r.count};
      end
    end else if (state_r == S_PW) begin
      we = 1'b1;
      if (ea_r.count > eb_r.count) begin
        waddr = ra_r;
        wdata = '{parent: ra_r, stamp: ea_r.stamp, count: ea_r.count + eb_r.count};
      end else begin
        waddr = rb_r;
        wdata = '{parent: rb_r, stamp: eb_r.stamp, count: ea_r.count + eb_r.count};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (out_v_r && out_tready) out_v_r <= 1'b0;
      unique case (state_r)
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == (NODE_W+1)'(NODES - 1)) state_r <= S_IDLE;
        end
        S_IDLE: if (in_tvalid && in_tready) begin
          op_r <= in_op; xb_r <= in_b; t_r <= in_t;
          cur_r <= in_a; sel_r <= 1'b0; ph_r <= 1'b0;
          plen_r <= '0; ma_r <= '0; mb_r <= '0; found_r <= 1'b0;
          best_r <= NEVER;
          if (in_op == OP_NONE) begin
            out_r <= '0; out_v_r <= 1'b1;
          end else if (in_a == in_b) begin
            out_r <= {63'd0, (in_op == OP_SAME)};
            out_v_r <= 1'b1;
          end else state_r <= S_RD;
        end
        S_RD: state_r <= S_WAIT;
        S_WAIT: state_r <= S_STEP;
        S_STEP: begin
          if (op_r == OP_EARLY && !ph_r) begin
            path_n[plen_r] <= cur_r; path_m[plen_r] <= ma_r;
            plen_r <= plen_r + 1'b1;
            if (is_root) begin
              ph_r <= 1'b1; cur_r <= xb_r; pidx_r <= '0; state_r <= S_PS;
            end else begin
              ma_r <= (rdata.stamp > ma_r) ? rdata.stamp : ma_r;
              cur_r <= rdata.parent; state_r <= S_RD;
            end
          end else if (op_r == OP_EARLY) begin
            if (is_root) state_r <= S_OUT;
            else begin
              mb_r <= (rdata.stamp > mb_r) ? rdata.stamp : mb_r;
              cur_r <= rdata.parent; pidx_r <= '0; state_r <= S_PS;
            end
          end else if (stop_here) begin
            if (!sel_r) begin
              ra_r <= cur_r; ea_r <= rdata; sel_r <= 1'b1; cur_r <= xb_r;
              state_r <= S_RD;
            end else begin
              rb_r <= cur_r; eb_r <= rdata;
              state_r <= (op_r == OP_UNITE) ? S_PB : S_OUT;
            end
          end else begin
            cur_r <= rdata.parent; state_r <= S_RD;
          end
        end
        // scan path of a for current b node
        S_PS: begin
          if (path_n[pidx_r] == cur_r) begin
            best_r <= (path_m[pidx_r] > mb_r) ? path_m[pidx_r] : mb_r;
            found_r <= 1'b1; state_r <= S_OUT;
          end else if (pidx_r == plen_r - 1'b1) state_r <= S_RD;
          else pidx_r <= pidx_r + 1'b1;
        end
        S_PB: state_r <= (ra_r == rb_r) ? S_OUT : S_LINK;
        S_LINK: state_r <= S_PW;
        S_PW: state_r <= S_OUT;
        S_OUT: begin
          unique case (op_r)
            OP_UNITE: out_r <= {2'b00, (ra_r != rb_r), 61'd0};
            OP_SAME: out_r <= {63'd0, (ra_r == rb_r)};
            // join stamps at or above 10^18 never connect within the answer range
            OP_EARLY: out_r <= {3'b000, (found_r && best_r < NEVER) ? best_r : NEVER, 1'b0};
            default: out_r <= '0;
          endcase
          out_v_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/tuf_checker.sv =====
// Port-level checks for the timestamped union-find block, bound to the top level.
module tuf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");
  a_noin: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input taken while result pending");
  a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[61]))
    else $error("result flags conflict");
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[63:62] == 2'b00)
    else $error("padding bits set");
endmodule

bind timestamped_union_find tuf_checker u_chk (.*);

// ===== tb/testbench.sv =====
// Testbench for the timestamped union-find block: directed and random traffic checked on the fly.
`timescale 1ns / 100ps

import tuf_pkg::*;

class forest_board;
  logic [NODE_W-1:0]  up   [NODES];
  logic [STAMP_W-1:0] when [NODES];
  int unsigned        sz   [NODES];
  logic [63:0]        pending_q[$];
  int                 errors;
  int                 checked;

  function void clear();
    for (int i = 0; i < NODES; i++) begin
      up[i] = NODE_W'(i);
      when[i] = NEVER;
      sz[i] = 1;
    end
    pending_q.delete();
    errors = 0;
    checked = 0;
  endfunction

  function int climb(int x, logic [STAMP_W-1:0] t, bit any);
    int steps;
    steps = 0;
    while (steps < NODES) begin
      if (up[x] == x) break;
      if (!any && when[x] > t) break;
      x = int'(up[x]);
      steps++;
    end
    return x;
  endfunction

  // Predict one result for an accepted input transfer and queue it.
  function void note_input(logic [87:0] d);
    op_t                op;
    int                 a, b, x, y, s;
    logic [STAMP_W-1:0] t, lo, hi, mid;
    logic [63:0]        r;
    op = op_t'(d[1:0]);
    a = int'(d[11:2]);
    b = int'(d[21:12]);
    t = d[81:22];
    r = '0;
    case (op)
      OP_UNITE: begin
        x = climb(a, t, 1);
        y = climb(b, t, 1);
        if (x != y) begin
          if (sz[x] > sz[y]) begin
            s = x; x = y; y = s;
          end
          up[x] = NODE_W'(y);
          when[x] = t;
          sz[y] = sz[x] + sz[y];
          r[61] = 1'b1;
        end
      end
      OP_SAME: r[0] = (climb(a, t, 0) == climb(b, t, 0));
      OP_EARLY: begin
        lo = '0;
        hi = NEVER;
        while (lo < hi) begin
          mid = lo + (hi - lo) / 2;
          if (climb(a, mid, 0) == climb(b, mid, 0)) hi = mid;
          else lo = mid + 1;
        end
        r[60:1] = hi;
      end
      default: ;
    endcase
    pending_q = {pending_q, r};
  endfunction

  function void check_result(logic [63:0] d);
    logic [63:0] e;
    if (pending_q.size() == 0) begin
      $display("%0t: unexpected result %h", $time, d);
      errors++;
      return;
    end
    e = pending_q.pop_front();
    checked++;
    if (d[0] !== e[0]) begin
      $display("%0t: connected exp %0d got %0d", $time, e[0], d[0]);
      errors++;
    end
    if (d[60:1] !== e[60:1]) begin
      $display("%0t: earliest_stamp exp %0d got %0d", $time, e[60:1], d[60:1]);
      errors++;
    end
    if (d[61] !== e[61]) begin
      $display("%0t: merged exp %0d got %0d", $time, e[61], d[61]);
      errors++;
    end
  endfunction
endclass

module testbench;
  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [87:0] in_tdata;   // opcode, node_a, node_b, stamp
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;  // connected, earliest_stamp, merged

  forest_board board;
  longint      cycles;
  bit          hold_off;
  logic [STAMP_W-1:0] unite_clock;
  int          pool;

  timestamped_union_find uut (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 3000000) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata);

  always @(posedge clk)
    if (rst_n && in_tvalid && in_tready) board.note_input(in_tdata);

  // Receiver: own stall pattern, plus one long hold-off on request.
  initial begin
    int n;
    out_tready = 0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_tready <= 0;
        n = 0;
        while (n < 400) begin
          @(negedge clk);
          n++;
        end
        hold_off = 0;
      end
      out_tready <= (cycles % 300 < 100) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  task automatic send(op_t op, int a, int b, logic [STAMP_W-1:0] t);
    in_tdata <= {6'd0, t, b[NODE_W-1:0], a[NODE_W-1:0], op};
    in_tvalid <= 1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic gap();
    int g;
    if ($urandom_range(0, 5) == 0) begin
      in_tvalid <= 0;
      g = $urandom_range(1, 30);
      repeat (g) @(negedge clk);
    end
  endtask

  function automatic logic [STAMP_W-1:0] rnd_stamp();
    logic [STAMP_W-1:0] s;
    case ($urandom_range(0, 4))
      0: s = '0;
      1: s = NEVER - 1;
      2: s = STAMP_W'({$urandom, $urandom});
      3: s = NEVER + $urandom_range(0, 5);
      default: s = unite_clock + $urandom_range(0, 2000) - 1000;
    endcase
    return s;
  endfunction

  initial begin
    int a, b, k;
    board = new();
    board.clear();
    hold_off = 0;
    unite_clock = 0;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed: each opcode, same node, field extremes, stamp edges, opcode 3.
    send(OP_SAME, 5, 5, 0);
    send(OP_EARLY, 7, 7, 0);
    send(OP_EARLY, 0, 1023, 0);
    send(OP_UNITE, 0, 1023, 10);
    send(OP_UNITE, 1023, 0, 20);
    send(OP_SAME, 0, 1023, 9);
    send(OP_SAME, 0, 1023, 10);
    send(OP_EARLY, 1023, 0, {STAMP_W{1'b1}});
    send(OP_UNITE, 1, 2, 30);
    send(OP_UNITE, 2, 0, 40);
    send(OP_SAME, 1, 1023, NEVER - 1);
    send(OP_SAME, 1, 1023, NEVER);
    send(OP_SAME, 1, 1023, {STAMP_W{1'b1}});
    send(OP_EARLY, 1, 1023, 0);
    send(OP_UNITE, 3, 4, 25);  // out-of-order stamp
    send(OP_UNITE, 4, 1, {STAMP_W{1'b1}});
    send(OP_SAME, 3, 0, NEVER - 1);
    send(OP_EARLY, 3, 0, 0);
    send(OP_NONE, 1023, 1023, {STAMP_W{1'b1}});
    send(OP_NONE, 0, 0, 0);
    unite_clock = 100;

    // Long receiver stall while the sender keeps offering.
    hold_off = 1;
    for (k = 0; k < 20; k++) send(OP_SAME, $urandom_range(0, 1023), $urandom_range(0, 1023),
                                  rnd_stamp());

    // Random: unites over a mostly small pool with mostly rising stamps, queries mixed in.
    for (k = 0; k < 1600; k++) begin
      gap();
      pool = (k % 400 < 300) ? 64 : 1024;
      a = $urandom_range(0, pool - 1);
      b = ($urandom_range(0, 9) == 0) ? a : $urandom_range(0, pool - 1);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          unite_clock = unite_clock + $urandom_range(0, 50);
          send(OP_UNITE, a, b, ($urandom_range(0, 30) == 0) ? rnd_stamp() : unite_clock);
        end
        4, 5, 6: send(OP_SAME, a, b, rnd_stamp());
        7, 8: send(OP_EARLY, a, b, rnd_stamp());
        default: send(op_t'($urandom_range(0, 3)), a, b, rnd_stamp());
      endcase
    end
    in_tvalid <= 0;

    while (board.pending_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Ran directed and about 1600 random unite/same/earliest items, %0d results checked.",
             board.checked);
    if (board.errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
